// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sndc_pkg.sv =====
package sndc_pkg;

   // Code-B values for the non-digit positions, and the largest digit code
   localparam logic [3:0] CODE_MINUS = 4'hA;
   localparam logic [3:0] CODE_BLANK = 4'hF;
   localparam logic [3:0] CODE_NINE  = 4'd9;

   // Largest number of chained displays served
   localparam int MAX_DISPLAYS = 8;

   // Register indexes on the csr port
   localparam logic CSR_DISPLAY_COUNT  = 1'b0;
   localparam logic CSR_DECODE_ENABLED = 1'b1;

   // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_TEN) >> RECIP_SHIFT
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

endpackage

// ===== rtl/signed_number_to_digit_codes.sv =====
// A number passes the input, working and result registers; DIGITS digits (8 by
// default) leave per number, one per cycle unless the result side stalls, each
// from a single divide-by-ten step (reciprocal multiply) on the magnitude.
// A second number waits in the input register while the current one is emitted.
// Reset clears all valid flags; display_count returns to 1 and decode to off.
module signed_number_to_digit_codes #(
   parameter int DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [2:0] display_index, [34:3] value, [35] leading_zeros, [39:36] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: [2:0] target_display, [5:3] digit_position, [9:6] digit_code,
   // [15:10] zero; rsp_tlast is last_write
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import sndc_pkg::*;

   localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);

   // Configuration registers
   logic [3:0] disp_count_ff, disp_count_in;
   logic       decode_ff, decode_in;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  in_idx_ff;
   logic [31:0] in_mag_ff;
   logic        in_neg_ff;
   logic        in_zeros_ff;

   // Working register for the number being emitted
   logic          busy_ff, busy_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic          zeros_ff, zeros_in;
   logic [2:0]    idx_ff, idx_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_disp_ff;
   logic [2:0]    rsp_pos_ff;
   logic [3:0]    rsp_code_ff;
   logic          rsp_last_ff;

   logic        req_fire;
   logic        active;
   logic [4:0]  count_ext;
   logic [4:0]  limit;
   logic        req_neg;
   logic [31:0] req_val;
   logic [31:0] req_mag;
   logic        step;
   logic        last_pos;
   logic        load;
   logic [63:0] prod;
   logic [31:0] quot;
   logic [31:0] times_ten;
   logic [31:0] rem;
   logic        show_digit;
   logic [3:0]  code;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      disp_count_in = disp_count_ff;
      decode_in     = decode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISPLAY_COUNT:  disp_count_in = csr_wdata;
            CSR_DECODE_ENABLED: decode_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Decide at acceptance whether the request yields any writes
   assign count_ext = {1'b0, disp_count_ff};
   assign limit     = (count_ext > 5'(MAX_DISPLAYS)) ? 5'(MAX_DISPLAYS) : count_ext;
   assign req_val   = req_tdata[34:3];
   assign req_neg   = req_val[31];
   assign req_mag   = req_neg ? (32'd0 - req_val) : req_val;
   assign active    = decode_ff && ({2'b00, req_tdata[2:0]} < limit);

   // Digit step: one divide by ten per cycle unless the result side stalls
   assign step     = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign last_pos = (pos_ff == LAST_POS);
   assign load     = in_valid_ff && (!busy_ff || (step && last_pos));

   assign req_tready = !in_valid_ff || load;
   assign req_fire   = req_tvalid && req_tready;

   assign prod       = 64'(mag_ff) * 64'(RECIP_TEN);
   assign quot       = 32'(prod[63:RECIP_SHIFT]);
   assign times_ten  = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
   assign rem        = mag_ff - times_ten;
   assign show_digit = (mag_ff != 32'd0) || (pos_ff == '0) || zeros_ff;
   assign code       = show_digit ? rem[3:0] : (neg_ff ? CODE_MINUS : CODE_BLANK);

   // Next values of the control flags and working state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = active;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      busy_in  = busy_ff;
      pos_in   = pos_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zeros_in = zeros_ff;
      idx_in   = idx_ff;
      if (load) begin
         busy_in  = 1'b1;
         pos_in   = '0;
         mag_in   = in_mag_ff;
         neg_in   = in_neg_ff;
         zeros_in = in_zeros_ff;
         idx_in   = in_idx_ff;
      end else if (step) begin
         pos_in = pos_ff + PW'(1);
         mag_in = quot;
         neg_in = neg_ff && show_digit;
         if (last_pos) begin
            busy_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_count_ff <= 4'd1;
         decode_ff     <= 1'b0;
         in_valid_ff   <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         disp_count_ff <= disp_count_in;
         decode_ff     <= decode_in;
         in_valid_ff   <= in_valid_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_idx_ff   <= req_tdata[2:0];
         in_mag_ff   <= req_mag;
         in_neg_ff   <= req_neg;
         in_zeros_ff <= req_tdata[35];
      end
      pos_ff   <= pos_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      zeros_ff <= zeros_in;
      idx_ff   <= idx_in;
      if (step) begin
         rsp_disp_ff <= idx_ff;
         rsp_pos_ff  <= 3'(pos_ff);
         rsp_code_ff <= code;
         rsp_last_ff <= last_pos;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_code_ff, rsp_pos_ff, rsp_disp_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/sndc_checker.sv =====
`include "assert_macros.svh"

module sndc_checker #(
   parameter int DIGITS = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   import sndc_pkg::*;

   logic [2:0] pos;
   logic [3:0] code;

   assign pos  = rsp_tdata[5:3];
   assign code = rsp_tdata[9:6];

   // Hold a stalled request steady
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "digit request changed while stalled")

   // Only digits, minus or blank leave the block
   `ASSERT_CLK(a_code_legal, clock, reset,
      rsp_tvalid |-> (code <= CODE_NINE) || (code == CODE_MINUS) || (code == CODE_BLANK),
      "illegal digit code")

   // Position zero always carries a decimal digit
   `ASSERT_CLK(a_pos0_digit, clock, reset,
      rsp_tvalid && (pos == 3'd0) |-> (code <= CODE_NINE),
      "position zero not a digit")

   // Last flag marks exactly the top position
   `ASSERT_CLK(a_last_pos, clock, reset,
      rsp_tvalid |-> (rsp_tlast == (pos == 3'(DIGITS - 1))),
      "last flag out of place")

   // Nothing is offered in the cycle after reset
   `ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_tvalid,
      "request offered after reset")

endmodule

bind signed_number_to_digit_codes sndc_checker #(.DIGITS(DIGITS)) u_sndc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/tb_signed_number_to_digit_codes.sv =====
module tb_signed_number_to_digit_codes;
   timeunit 1ns;
   timeprecision 1ps;

   import sndc_pkg::*;

   localparam int DIGITS           = 8;
   localparam int RESET_CYCLES     = 9;
   localparam int SETTLE_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLD_OFF_CYCLES  = 64;
   localparam int RANDOM_PHASES    = 4;
   localparam int NUMBERS_PER_PHASE = 88;
   localparam int DIRECTED_ROWS    = 27;
   localparam int REPORT_LIMIT     = 10;

   typedef enum logic {ROW_NUMBER, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_CODES} row_check_type;

   typedef struct {
      row_kind_type  kind;
      logic          csr_index;
      logic [3:0]    csr_data;
      logic [2:0]    display;
      logic [31:0]   number;
      logic          zeros;
      row_check_type check;
      logic [31:0]   codes;   // position 0 in the lowest nibble
   } directed_row_type;

   typedef struct packed {
      logic [2:0] display;
      logic [2:0] position;
      logic [3:0] code;
      logic       last;
   } digit_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_DISPLAY_COUNT;
   logic [3:0]  csr_wdata = '0;

   // Copy of the register file as the block should hold it
   logic [3:0]  shown_count  = 4'd1;
   logic        shown_decode = 1'b0;

   digit_write_type  pending_writes[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   int               rsp_stall_pct  = 0;
   int               hold_off_cycles = 0;

   signed_number_to_digit_codes #(.DIGITS(DIGITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Number of displays actually served, with the count clipped to the chain size
   function automatic int unsigned displays_in_use();
      return (shown_count > MAX_DISPLAYS) ? MAX_DISPLAYS : shown_count;
   endfunction

   function automatic bit display_served(input logic [2:0] display);
      return shown_decode && (display < displays_in_use());
   endfunction

   // Code-B values for all positions, position 0 in the lowest nibble
   function automatic logic [31:0] digit_codes(input logic [31:0] number, input logic zeros);
      logic [31:0] magnitude;
      logic [31:0] codes;
      logic        sign_due;
      sign_due  = number[31];
      magnitude = sign_due ? (32'd0 - number) : number;
      codes     = '0;
      for (int pos = 0; pos < DIGITS; pos++) begin
         if (magnitude != 0 || pos == 0 || zeros) begin
            codes[4*pos +: 4] = 4'(magnitude % 10);
            magnitude         = magnitude / 10;
         end else if (sign_due) begin
            codes[4*pos +: 4] = CODE_MINUS;
            sign_due          = 1'b0;
         end else begin
            codes[4*pos +: 4] = CODE_BLANK;
         end
      end
      return codes;
   endfunction

   task automatic queue_digit_writes(input logic [2:0] display, input logic [31:0] codes);
      for (int pos = 0; pos < DIGITS; pos++)
         pending_writes.push_back('{display, 3'(pos), codes[4*pos +: 4], pos == DIGITS - 1});
   endtask

   function automatic directed_row_type number_row(input logic [2:0] display,
                                                   input int number, input logic zeros,
                                                   input row_check_type check,
                                                   input logic [31:0] codes);
      return '{ROW_NUMBER, CSR_DISPLAY_COUNT, 4'd0, display, number, zeros, check, codes};
   endfunction

   function automatic directed_row_type csr_row(input logic index, input logic [3:0] data);
      return '{ROW_CSR, index, data, 3'd0, 32'd0, 1'b0, CHK_NONE, 32'd0};
   endfunction

   // Offer one request and book its digit writes once it is taken
   task automatic send_number(input logic [2:0] display, input logic [31:0] number,
                              input logic zeros, input row_check_type check,
                              input logic [31:0] codes);
      req_tdata  <= {4'b0, zeros, number, display};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      case (check)
         CHK_CODES:   queue_digit_writes(display, codes);
         CHK_PREDICT: if (display_served(display))
                         queue_digit_writes(display, digit_codes(number, zeros));
         default: ;
      endcase
   endtask

   // Hold the request channel low for a random stretch
   task automatic sender_gap(input int gap_pct);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
   endtask

   // Drain the block, let it settle, then write one register
   task automatic write_register(input logic index, input logic [3:0] data);
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_DISPLAY_COUNT)
         shown_count = data;
      else
         shown_decode = data[0];
   endtask

   function automatic logic [31:0] random_number();
      int unsigned span;
      logic [31:0] number;
      case ($urandom_range(0, 3))
         0: number = $urandom;
         1: begin
            span = 1;
            repeat ($urandom_range(1, 9)) span = span * 10;
            number = $urandom_range(0, span - 1);
            if ($urandom_range(0, 1)) number = -number;
         end
         2: begin
            number = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) number = -number;
         end
         default: begin
            case ($urandom_range(0, 9))
               0: number = 32'h8000_0000;
               1: number = 32'h7FFF_FFFF;
               2: number = 32'h8000_0001;
               3: number = 99999999;
               4: number = -99999999;
               5: number = 100000000;
               6: number = -100000000;
               7: number = 9999999;
               8: number = -9999999;
               default: number = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return number;
   endfunction

   function automatic logic [2:0] random_display();
      int unsigned served;
      served = displays_in_use();
      if (served != 0 && $urandom_range(0, 9) < 8)
         return 3'($urandom_range(0, served - 1));
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic flag_mismatch(input string what, input digit_write_type want,
                                input digit_write_type seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected display %0d pos %0d code %h last %b",
                  want.display, want.position, want.code, want.last);
         $display("   got      display %0d pos %0d code %h last %b",
                  seen.display, seen.position, seen.code, seen.last);
      end
   endtask

   // Compare each digit write with the oldest one booked
   always @(posedge clock) begin
      digit_write_type seen;
      digit_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata[2:0], rsp_tdata[5:3], rsp_tdata[9:6], rsp_tlast};
         if (pending_writes.size() == 0) begin
            flag_mismatch("digit write with nothing pending", '0, seen);
         end else begin
            want = pending_writes.pop_front();
            if (seen != want) flag_mismatch("digit write mismatch", want, seen);
         end
      end
   end

   // Drive the result side ready, with an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int gap_pct_by_phase[RANDOM_PHASES];
      int stall_pct_by_phase[RANDOM_PHASES];
      logic [3:0] count_by_phase[RANDOM_PHASES];

      gap_pct_by_phase   = '{0, 54, 0, 22};
      stall_pct_by_phase = '{0, 0, 54, 22};
      count_by_phase     = '{4'd8, 4'd1, 4'($urandom_range(2, 7)), 4'($urandom_range(9, 15))};

      directed_rows = '{
         // decode off straight after reset
         number_row(3'd0, 5, 1'b0, CHK_NONE, '0),
         csr_row(CSR_DECODE_ENABLED, 4'hF),
         number_row(3'd0, 0, 1'b0, CHK_CODES, 32'hFFFF_FFF0),
         // index beyond the single display in use
         number_row(3'd1, 7, 1'b0, CHK_NONE, '0),
         csr_row(CSR_DISPLAY_COUNT, 4'd8),
         number_row(3'd7, 32'h7FFF_FFFF, 1'b0, CHK_CODES, 32'h4748_3647),
         number_row(3'd0, 32'h8000_0001, 1'b0, CHK_CODES, 32'h4748_3647),
         // most negative value shows its magnitude
         number_row(3'd3, 32'h8000_0000, 1'b0, CHK_CODES, 32'h4748_3648),
         number_row(3'd2, -1, 1'b0, CHK_CODES, 32'hFFFF_FFA1),
         // leading zeros drop the sign
         number_row(3'd5, -1, 1'b1, CHK_CODES, 32'h0000_0001),
         number_row(3'd6, 0, 1'b1, CHK_CODES, 32'h0000_0000),
         number_row(3'd4, 99999999, 1'b0, CHK_CODES, 32'h9999_9999),
         // eight digits leave no room for the minus
         number_row(3'd1, -99999999, 1'b0, CHK_CODES, 32'h9999_9999),
         number_row(3'd0, -9999999, 1'b0, CHK_CODES, 32'hA999_9999),
         number_row(3'd7, 100000000, 1'b0, CHK_CODES, 32'h0000_0000),
         number_row(3'd2, 12345, 1'b0, CHK_PREDICT, '0),
         number_row(3'd3, -305, 1'b0, CHK_PREDICT, '0),
         // count above the chain size is clipped
         csr_row(CSR_DISPLAY_COUNT, 4'hF),
         number_row(3'd7, 42, 1'b0, CHK_PREDICT, '0),
         // no display in use
         csr_row(CSR_DISPLAY_COUNT, 4'd0),
         number_row(3'd0, 1, 1'b0, CHK_NONE, '0),
         csr_row(CSR_DISPLAY_COUNT, 4'd3),
         number_row(3'd2, -8, 1'b0, CHK_PREDICT, '0),
         number_row(3'd3, 8, 1'b0, CHK_NONE, '0),
         csr_row(CSR_DECODE_ENABLED, 4'hE),
         number_row(3'd0, 99, 1'b0, CHK_NONE, '0),
         csr_row(CSR_DECODE_ENABLED, 4'h1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      shown_count  = 4'd1;
      shown_decode = 1'b0;

      // Walk the directed table back to back
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_register(directed_rows[r].csr_index, directed_rows[r].csr_data);
         else
            send_number(directed_rows[r].display, directed_rows[r].number,
                        directed_rows[r].zeros, directed_rows[r].check,
                        directed_rows[r].codes);
      end

      // Random requests, one setting of both registers and one idling mix per phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_register(CSR_DISPLAY_COUNT, count_by_phase[phase]);
         write_register(CSR_DECODE_ENABLED, {3'($urandom_range(0, 7)), 1'b1});
         rsp_stall_pct = stall_pct_by_phase[phase];
         for (int n = 0; n < NUMBERS_PER_PHASE; n++) begin
            // stall the result side while requests keep coming
            if (phase == 0 && n == 30) hold_off_cycles = HOLD_OFF_CYCLES;
            send_number(random_display(), random_number(), $urandom_range(0, 3) == 0,
                        CHK_PREDICT, '0);
            if (n != NUMBERS_PER_PHASE - 1) sender_gap(gap_pct_by_phase[phase]);
         end
      end

      // Drain and let the block settle
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sndc_pkg.sv
rtl/signed_number_to_digit_codes.sv
rtl/sndc_checker.sv
bench/tb_signed_number_to_digit_codes.sv
